// File: rtl/estf_pkg.sv
// Package for the encoder speed trimmed-mean filter.
// Holds widths, register codes, reset values and the shared types.
// No dependencies.
package estf_pkg;

    localparam int WINDOW_DEF      = 10;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int SAMPLE_W    = 32;
    localparam int INTERVAL_W  = 8;
    localparam int SCALE_W     = 24;
    localparam int WEIGHT_W    = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT   = 2'd2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 8'd5;
    localparam logic [SCALE_W-1:0]    SCALE_RST    = 24'd65536;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_RST   = 17'd31457;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam int                  ROUND_HALF = 32768;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                   cmd;
        logic signed [SAMPLE_W-1:0]  sample;
    } cell_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  value;
        logic                        valid;
        logic                        greater;
    } cell_link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INSERT,
        ST_SUM,
        ST_DIV,
        ST_WMUL,
        ST_EMUL,
        ST_FILT
    } state_t;

endpackage

// File: rtl/estf_cell.sv
// One cell of the insertion-sort chain: holds one sample and its valid bit.
// Depends on estf_pkg for the cell control and link types.
module estf_cell
    import estf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t self
);

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       greater;

    // An empty cell counts as larger than any sample.
    assign greater = !valid_reg || ($signed(value_reg) > $signed(ctl.sample));

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctl.cmd)
            CELL_INSERT:
            begin
                if (greater)
                begin
                    // First larger cell takes the new sample, the rest move up one.
                    if (!left.greater)
                    begin
                        value_next = ctl.sample;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        value_next = left.value;
                        valid_next = left.valid;
                    end
                end
            end
            CELL_SHIFT:
            begin
                value_next = right.value;
                valid_next = right.valid;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign self.value   = value_reg;
    assign self.valid   = valid_reg;
    assign self.greater = greater;

endmodule

// File: rtl/estf_div.sv
// Signed divider by a fixed divisor, truncating toward zero.
// Multiplies the magnitude by a scaled reciprocal, 16 bits of the magnitude per cycle.
// Depends on estf_pkg for the sample width.
module estf_div
    import estf_pkg::*;
#(
    parameter int DIVISOR = WINDOW_DEF - 4,
    parameter int SUMW    = 36
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SUMW-1:0]     dividend,
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] quotient
);

    localparam int     CHUNK_W = 16;
    localparam int     NCH     = (SUMW + CHUNK_W - 1) / CHUNK_W;
    localparam int     MAGW    = NCH * CHUNK_W;
    localparam int     RECW    = SUMW;
    localparam int     PRODW   = MAGW + RECW;
    localparam int     SHIFT   = SUMW - 1 + $clog2(DIVISOR);
    localparam int     CNTW    = $clog2(NCH + 1);
    // Rounded-up reciprocal; exact floor for magnitudes below 2^(SUMW-1).
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR - 1))
                                 / longint'(DIVISOR);
    localparam logic [RECW-1:0] RECIP = RECW'(RECIP_L);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [MAGW-1:0]         mag_reg, mag_next;
    logic [PRODW-1:0]        prod_reg, prod_next;
    logic                    neg_reg, neg_next;
    logic [SUMW-1:0]         dvd_abs;
    logic [CHUNK_W-1:0]      chunk;
    logic [CHUNK_W+RECW-1:0] part;
    logic [SAMPLE_W-1:0]     quo_mag;

    assign dvd_abs = dividend[SUMW-1] ? (~dividend + 1'b1) : dividend;

    // Horner form: consume the magnitude from its top 16 bits down.
    assign chunk = mag_reg[MAGW-1 -: CHUNK_W];
    assign part  = chunk * RECIP;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NCH);
            mag_next  = MAGW'(dvd_abs);
            prod_next = '0;
            neg_next  = dividend[SUMW-1];
        end
        else if (busy_reg)
        begin
            prod_next = {prod_reg[PRODW-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PRODW'(part);
            mag_next  = {mag_reg[MAGW-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
    end

    assign quo_mag  = prod_reg[SHIFT +: SAMPLE_W];
    assign quotient = neg_reg ? (~quo_mag + 1'b1) : quo_mag;
    assign done     = done_reg;

endmodule

// File: rtl/encoder_speed_trimmed_filter.sv
// Top level of the encoder speed trimmed-mean filter.
// Depends on estf_pkg, estf_cell and estf_div.
//
// One encoder count is taken per tick. Every interval_ticks ticks the count
// delta is scaled to rpm Q.8 and inserted into a chain of WINDOW sorting
// cells; when WINDOW samples are in, the chain is shifted out to sum the
// middle WINDOW-4, a reciprocal-multiply divider forms the mean, and a
// first-order low-pass update produces one result. A tick without a sample
// is taken in the idle state; a sampling tick then passes the multiply and
// insert states, and the tick that closes a window also the chain shift-out,
// the divider's 16-bit multiply steps (SUMW = 33 + clog2(WINDOW-4)), the
// weight multiplies and the filter update. The input is stalled until that
// work is done, and longer while the previous result still waits in the
// output register; a finished result waits there while the next
// items are taken.
module encoder_speed_trimmed_filter
    import estf_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_W-1:0]    encoder_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_W-1:0]    trimmed_mean,
    output logic signed [SAMPLE_W-1:0]    filtered_speed,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic        [CFG_INDEX_W-1:0] cfg_index,
    input  logic        [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MIDDLE = WINDOW - 4;
    localparam int SUMW   = SAMPLE_W + 1 + $clog2(MIDDLE);
    localparam int CNTW   = $clog2(WINDOW + 1);
    localparam int PRODW  = COUNT_WIDTH + SCALE_W + 1;
    localparam int FPW    = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACCW   = FPW + 1;

    state_t state_reg, state_next;

    logic [INTERVAL_W-1:0] interval_reg;
    logic [SCALE_W-1:0]    scale_reg;
    logic [WEIGHT_W-1:0]   weight_reg;

    logic [INTERVAL_W-1:0]         tick_reg, tick_next;
    logic [COUNT_WIDTH-1:0]        last_reg, last_next;
    logic [CNTW-1:0]               count_reg, count_next;
    logic signed [SAMPLE_W-1:0]    est_reg, est_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [COUNT_WIDTH-1:0] delta_reg, delta_next;
    logic signed [PRODW-1:0]       prod_reg, prod_next;
    logic signed [SUMW-1:0]        sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0]    mean_reg, mean_next;
    logic signed [FPW-1:0]         wprod_reg, wprod_next;
    logic signed [FPW-1:0]         eprod_reg, eprod_next;
    logic signed [SAMPLE_W-1:0]    tm_reg, tm_next;
    logic signed [SAMPLE_W-1:0]    fs_reg, fs_next;

    logic                          in_xfer;
    logic                          take_sample;
    logic                          out_free;
    logic                          window_full;
    logic                          sum_last;
    logic                          in_middle;
    logic [PRODW-SAMPLE_W-8:0]     prod_upper;
    logic signed [SAMPLE_W-1:0]    sample_sat;
    logic [WEIGHT_W-1:0]           w_sat;
    logic [WEIGHT_W-1:0]           w_inv;
    logic signed [ACCW-1:0]        acc;
    logic signed [SAMPLE_W-1:0]    head;

    cell_ctl_t                     cell_ctl;
    cell_link_t                    link [WINDOW];
    logic                          div_start;
    logic                          div_done;
    logic signed [SAMPLE_W-1:0]    div_quotient;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RST;
            scale_reg    <= SCALE_RST;
            weight_reg   <= WEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                CFG_SCALE:    scale_reg    <= cfg_data[SCALE_W-1:0];
                CFG_WEIGHT:   weight_reg   <= cfg_data[WEIGHT_W-1:0];
                default:      interval_reg <= interval_reg;
            endcase
        end
    end

    assign in_xfer     = in_valid && !in_stall;
    assign take_sample = (tick_reg == interval_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign window_full = (count_reg == CNTW'(WINDOW - 1));
    assign sum_last    = (count_reg == CNTW'(WINDOW - 1));
    assign in_middle   = (count_reg >= CNTW'(2)) && (count_reg <= CNTW'(WINDOW - 3));
    assign head        = link[0].value;

    // Floor shift by 8, then saturate to 32 bits.
    assign prod_upper = prod_reg[PRODW-1:SAMPLE_W+7];
    always_comb
    begin
        if ((&prod_upper) || !(|prod_upper))
        begin
            sample_sat = prod_reg[SAMPLE_W+7:8];
        end
        else
        begin
            sample_sat = prod_reg[PRODW-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    assign w_sat = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign w_inv = WEIGHT_ONE - w_sat;
    assign acc   = {wprod_reg[FPW-1], wprod_reg} + {eprod_reg[FPW-1], eprod_reg}
                   + ACCW'(ROUND_HALF);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && take_sample)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_INSERT;
            ST_INSERT: state_next = window_full ? ST_SUM : ST_IDLE;
            ST_SUM:    state_next = sum_last ? ST_DIV : ST_SUM;
            ST_DIV:    state_next = div_done ? ST_WMUL : ST_DIV;
            ST_WMUL:   state_next = ST_EMUL;
            ST_EMUL:   state_next = ST_FILT;
            ST_FILT:   state_next = out_free ? ST_IDLE : ST_FILT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall        = 1'b1;
        cell_ctl.cmd    = CELL_HOLD;
        cell_ctl.sample = sample_sat;
        div_start       = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall     = 1'b0;
            ST_INSERT: cell_ctl.cmd = CELL_INSERT;
            ST_SUM:
            begin
                cell_ctl.cmd = CELL_SHIFT;
                div_start    = sum_last;
            end
            default:   in_stall     = 1'b1;
        endcase
    end

    // Datapath
    always_comb
    begin
        tick_next      = tick_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        est_next       = est_reg;
        out_valid_next = out_valid_reg && out_stall;
        delta_next     = delta_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        wprod_next     = wprod_reg;
        eprod_next     = eprod_reg;
        tm_next        = tm_reg;
        fs_next        = fs_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (take_sample)
                    begin
                        tick_next  = INTERVAL_W'(1);
                        delta_next = encoder_count[COUNT_WIDTH-1:0] - last_reg;
                        last_next  = encoder_count[COUNT_WIDTH-1:0];
                    end
                    else
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = delta_reg * $signed({1'b0, scale_reg});
            end
            ST_INSERT:
            begin
                if (window_full)
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                // Drain the sorted chain from the small end, keep the middle.
                if (in_middle)
                begin
                    sum_next = sum_reg + {{(SUMW-SAMPLE_W){head[SAMPLE_W-1]}}, head};
                end
                count_next = sum_last ? '0 : count_reg + 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next = div_quotient;
                end
            end
            ST_WMUL:
            begin
                wprod_next = $signed({1'b0, w_sat}) * mean_reg;
            end
            ST_EMUL:
            begin
                eprod_next = $signed({1'b0, w_inv}) * est_reg;
            end
            ST_FILT:
            begin
                if (out_free)
                begin
                    // Weighted blend stays inside the 32-bit range.
                    est_next       = acc[SAMPLE_W+15:16];
                    tm_next        = mean_reg;
                    fs_next        = acc[SAMPLE_W+15:16];
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            last_reg      <= '0;
            count_reg     <= '0;
            est_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            est_reg       <= est_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        mean_reg  <= mean_next;
        wprod_reg <= wprod_next;
        eprod_reg <= eprod_next;
        tm_reg    <= tm_next;
        fs_reg    <= fs_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            cell_link_t left_link;
            cell_link_t right_link;

            if (gi == 0)
            begin : g_first
                assign left_link = '{value: '0, valid: 1'b1, greater: 1'b0};
            end
            else
            begin : g_inner_left
                assign left_link = link[gi-1];
            end

            if (gi == WINDOW - 1)
            begin : g_last
                assign right_link = '{value: '0, valid: 1'b0, greater: 1'b1};
            end
            else
            begin : g_inner_right
                assign right_link = link[gi+1];
            end

            estf_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (cell_ctl),
                .left  (left_link),
                .right (right_link),
                .self  (link[gi])
            );
        end
    endgenerate

    estf_div
    #(
        .DIVISOR (MIDDLE),
        .SUMW    (SUMW)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid      = out_valid_reg;
    assign trimmed_mean   = tm_reg;
    assign filtered_speed = fs_reg;

endmodule
